>>> hdl/modinv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse package
// Sequencer states and the reset modulus shared by the modular inverse block.
// ----------------------------------------------------------------------------
package modinv_pkg;

  // Modulus after reset.
  localparam int MOD_RESET = 26;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_LOOP,
    S_STEP,
    S_OUT
  } modinv_state_t;

endpackage

>>> hdl/modinv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse channel interfaces
// Valid/ready channels for the modulus write, the input value and the result.
// ----------------------------------------------------------------------------
interface modinv_cfg_if #(parameter int WIDTH = 16);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

interface modinv_in_if #(parameter int WIDTH = 16);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface modinv_out_if #(parameter int WIDTH = 16);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] inverse;
  logic             no_inverse;

  modport source (output valid, output inverse, output no_inverse, input ready);
  modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

>>> hdl/modinv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse division step unit
// Radix-2 restoring divider, one quotient bit per cycle. Each quotient bit
// also feeds a Horner accumulator, so the unit returns the remainder and
// t_add + quotient * t_mul together.
// ----------------------------------------------------------------------------
module modinv_div #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  input  logic [WIDTH-1:0] t_mul,
  input  logic [WIDTH-1:0] t_add,
  output logic             done,
  output logic [WIDTH-1:0] remainder,
  output logic [WIDTH:0]   t_out
);

  localparam int CW = $clog2(WIDTH);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] dsr;
  logic [WIDTH-1:0] tmul;
  logic [WIDTH-1:0] tadd;
  logic [WIDTH:0]   acc;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   rem_diff;
  logic             qbit;
  logic [WIDTH:0]   acc_next;

  always_comb begin
    rem_sh   = {rem, dvd[WIDTH-1]};
    rem_diff = rem_sh - {1'b0, dsr};
    qbit     = (rem_sh >= {1'b0, dsr});
    acc_next = {acc[WIDTH-1:0], 1'b0} + (qbit ? {1'b0, tmul} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvd  <= dividend;
      dsr  <= divisor;
      tmul <= t_mul;
      tadd <= t_add;
      acc  <= '0;
    end else if (busy) begin
      rem <= qbit ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      dvd <= {dvd[WIDTH-2:0], 1'b0};
      acc <= acc_next;
    end
  end

  assign remainder = rem;
  assign t_out     = acc + {1'b0, tadd};

endmodule

>>> hdl/modular_inverse_ext_euclid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse by extended Euclid
// Computes the multiplicative inverse of a value against a programmed
// modulus, with a flag when none exists.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    - write channel for the modulus. Always ready; write it only while
//            the block is idle. Reset loads 26.
//   item   - input value. A transaction is taken only in the idle state; the
//            block then holds ready low until its result has been taken.
//   result - inverse and no_inverse, held in an output register with valid
//            high until the receiver raises ready. A stalled receiver simply
//            keeps the block waiting; nothing is dropped.
// Sequencing: one shared restoring divider produces one quotient bit per
//   cycle. The item is first reduced against the modulus, then each Euclid
//   step is one more division on the same divider, with a sequencer state
//   between divisions (up to about 23 Euclid steps at 16 bits). A modulus
//   below 2 skips the divider and goes straight to the result. A new item
//   is taken only after the previous result has been taken.
// Reset: synchronous, clears the sequencer and output valid and reloads the
//   modulus; no clearing pass is needed.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid
  import modinv_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input logic         clk,
  input logic         rst,
  modinv_cfg_if.sink  cfg,
  modinv_in_if.sink   item,
  modinv_out_if.source result
);

  modinv_state_t state;
  modinv_state_t state_next;

  // Programmed modulus and the per-item working set.
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] m_r;
  logic [WIDTH-1:0] r_old;
  logic [WIDTH-1:0] r_new;
  logic [WIDTH-1:0] t_old;
  logic [WIDTH-1:0] t_new;
  logic             neg;
  logic [WIDTH-1:0] inverse;
  logic             no_inverse;

  // Shared divider hookup.
  logic             div_start;
  logic [WIDTH-1:0] div_dividend;
  logic [WIDTH-1:0] div_divisor;
  logic             div_done;
  logic [WIDTH-1:0] div_rem;
  logic [WIDTH:0]   div_t;

  logic             accept;
  logic             mod_small;

  assign cfg.ready  = 1'b1;
  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign mod_small  = (modulus < WIDTH'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(MOD_RESET);
    end else if (cfg.valid && cfg.ready) begin
      modulus <= cfg.modulus;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and divider launch.
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = r_old;
    div_divisor  = r_new;
    case (state)
      S_IDLE: begin
        div_dividend = item.value;
        div_divisor  = modulus;
        if (accept) begin
          if (mod_small) begin
            state_next = S_OUT;
          end else begin
            div_start  = 1'b1;
            state_next = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (div_done) state_next = S_LOOP;
      end
      S_LOOP: begin
        if (r_new <= WIDTH'(1)) begin
          state_next = S_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (div_done) state_next = S_LOOP;
      end
      S_OUT: begin
        if (result.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Euclid registers: advance one step per finished division.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        m_r        <= modulus;
        inverse    <= '0;
        no_inverse <= 1'b1;
      end
      S_REDUCE: begin
        if (div_done) begin
          r_old <= m_r;
          r_new <= div_rem;
          t_old <= '0;
          t_new <= WIDTH'(1);
          neg   <= 1'b0;
        end
      end
      S_LOOP: begin
        if (r_new == '0) begin
          // Common factor above one: no inverse.
          inverse    <= '0;
          no_inverse <= 1'b1;
        end else if (r_new == WIDTH'(1)) begin
          // Map a negative coefficient into range.
          inverse    <= neg ? (m_r - t_new) : t_new;
          no_inverse <= 1'b0;
        end
      end
      S_STEP: begin
        if (div_done) begin
          r_old <= r_new;
          r_new <= div_rem;
          t_old <= t_new;
          t_new <= div_t[WIDTH-1:0];
          neg   <= !neg;
        end
      end
      default: ;
    endcase
  end

  modinv_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .t_mul    (t_new),
    .t_add    (t_old),
    .done     (div_done),
    .remainder(div_rem),
    .t_out    (div_t)
  );

  assign result.valid      = (state == S_OUT);
  assign result.inverse    = inverse;
  assign result.no_inverse = no_inverse;

`ifndef NO_ASSERTIONS
  // Input stays closed while a result waits.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !item.ready)
    else $error("input ready while result pending");

  // Taking an item closes the input for the next cycle.
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("input ready right after accept");

  // Flagged results carry a zero inverse.
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.no_inverse) |-> (result.inverse == '0))
    else $error("nonzero inverse with no_inverse set");

  // A real inverse lies below the modulus of its item.
  a_in_range: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.no_inverse) |-> (result.inverse < m_r))
    else $error("inverse out of range");
`endif

endmodule
